[rtl/bsq_pkg.sv]
`default_nettype none
package bsq_pkg;

	// physical store depth and field widths
	localparam int unsigned DEPTH_DEF  = 1024;
	localparam int unsigned ITEM_W     = 32;
	localparam int unsigned CFG_W      = 11;
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned OUT_CNT_W  = 11;
	localparam int unsigned CFG_IDX_W  = 1;

	// packed stream widths, padded to whole bytes
	localparam int unsigned IN_FIELDS_W  = FUNC_W + IDX_W + ITEM_W;
	localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELDS_W = STATUS_W + ITEM_W + 2 * OUT_CNT_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// register reset values
	localparam logic [CFG_W-1:0] INIT_CAP_RST = CFG_W'(16);
	localparam logic [CFG_W-1:0] BLOCK_RST    = CFG_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INIT_CAP = 1'b0,
		REG_BLOCK    = 1'b1
	} reg_idx_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 2'd0,
		FN_REMOVE = 2'd1,
		FN_GET    = 2'd2,
		FN_SET    = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_INVALID  = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_BOUNDS   = 3'd3,
		ST_GROW     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		STATE_IDLE = 2'b01,
		STATE_READ = 2'b10
	} state_t;

endpackage
`default_nettype wire

[rtl/bsq_ram.sv]
`default_nettype none
module bsq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/bounded_stack_with_capacity_quota_unit.sv]
//  channel   | dir | handshake                   | payload (lowest bit up)
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | func, index, item_value
//  m_axis    | out | m_axis_tvalid/m_axis_tready | status, item_out, item_count, capacity_now
//  cfg       | in  | cfg_we (no back-pressure)   | cfg_index, cfg_data
//
//  append, set and every rejected item load the result register directly; remove and get wait in STATE_READ:
//  the item store is a ram with a registered read port
//  one item at a time; a new item enters at the earliest as the waiting result leaves
//  arst_n clears counters, registers and handshake state; the item store is not cleared
//  a stalled m_axis holds the result and stops intake until the result register frees
`default_nettype none
module bounded_stack_with_capacity_quota_unit #(
	parameter int unsigned DEPTH = bsq_pkg::DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// cfg: 0 initial_capacity, 1 block_size
	input  wire logic                              cfg_we,
	input  wire logic [bsq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bsq_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// func[1:0], index[11:2], item_value[43:12], zero fill above
	input  wire logic [bsq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// status[2:0], item_out[34:3], item_count[45:35], capacity_now[56:46], zero fill above
	output logic      [bsq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import bsq_pkg::*;

	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	// one spare bit so capacity plus block never wraps
	localparam int unsigned VW     = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam logic [VW-1:0] DEPTH_V = VW'(DEPTH);

	// configuration and stack counters
	logic [CFG_W-1:0] init_q, blk_q;
	logic [VW-1:0]    count_q, cap_q;
	state_t           state_q;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [ITEM_W-1:0]   out_item_q;
	logic [OUT_CNT_W-1:0] out_count_q, out_cap_q;

	// unpacked input item
	func_t             func;
	logic [IDX_W-1:0]  idx;
	logic [ITEM_W-1:0] item;
	logic              in_acc;

	assign func   = func_t'(s_axis_tdata[FUNC_W-1:0]);
	assign idx    = s_axis_tdata[FUNC_W +: IDX_W];
	assign item   = s_axis_tdata[FUNC_W+IDX_W +: ITEM_W];
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// intake only from idle, and only when the result register can take a result
	assign s_axis_tready = (state_q == STATE_IDLE) && (!out_valid_q || m_axis_tready);

	// derived values
	logic [VW-1:0] init_v, blk_v, blk2_v, idx_v, limit, grow_sum, cnt_m1, slack;
	logic          full, shrink_ok, both_zero, idx_ok;

	assign init_v    = VW'(init_q);
	assign blk_v     = VW'(blk_q);
	assign blk2_v    = {blk_v[VW-2:0], 1'b0};
	assign idx_v     = VW'(idx);
	assign limit     = (cap_q < DEPTH_V) ? cap_q : DEPTH_V;
	assign full      = (count_q >= limit);
	assign grow_sum  = cap_q + blk_v;
	assign cnt_m1    = count_q - VW'(1);
	assign slack     = cap_q - count_q;
	// shrink by one block when slack covers two blocks and the floor holds
	assign shrink_ok = (cap_q >= blk_v) && (cap_q >= count_q) && (slack >= blk2_v)
		&& ((cap_q - blk_v) >= init_v);
	assign both_zero = (init_q == '0) && (blk_q == '0);
	assign idx_ok    = (idx_v < count_q);

	// next-state decision for the accepted item
	status_t           nxt_status;
	logic [VW-1:0]     nxt_count, nxt_cap;
	logic              rd_op, ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [ITEM_W-1:0] ram_rdata;

	always_comb begin
		nxt_status = ST_OK;
		nxt_count  = count_q;
		nxt_cap    = cap_q;
		rd_op      = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = count_q[ADDR_W-1:0];
		ram_raddr  = cnt_m1[ADDR_W-1:0];
		if (both_zero) begin
			nxt_status = ST_INVALID;
		end else begin
			unique case (func)
				FN_APPEND: begin
					if (item == '0) begin
						nxt_status = ST_INVALID;
					end else begin
						if (full) begin
							if (blk_q == '0) begin
								nxt_status = ST_OVERFLOW;
							end else if (grow_sum > DEPTH_V) begin
								nxt_status = ST_GROW;
							end else begin
								nxt_cap = grow_sum;
							end
						end
						// grown but the physical store is still out of room
						if (nxt_status == ST_OK) begin
							if (count_q < DEPTH_V) begin
								ram_we    = 1'b1;
								nxt_count = count_q + VW'(1);
							end else begin
								nxt_status = ST_GROW;
							end
						end
					end
				end
				FN_REMOVE: begin
					if (count_q == '0) begin
						nxt_status = ST_OVERFLOW;
					end else begin
						if (shrink_ok) begin
							nxt_cap = cap_q - blk_v;
						end
						rd_op     = 1'b1;
						nxt_count = cnt_m1;
					end
				end
				FN_GET: begin
					if (!idx_ok) begin
						nxt_status = ST_BOUNDS;
					end else begin
						rd_op     = 1'b1;
						ram_raddr = idx_v[ADDR_W-1:0];
					end
				end
				FN_SET: begin
					if (item == '0) begin
						nxt_status = ST_INVALID;
					end else if (!idx_ok) begin
						nxt_status = ST_BOUNDS;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = idx_v[ADDR_W-1:0];
					end
				end
				default: begin
					nxt_status = ST_INVALID;
				end
			endcase
		end
	end

	bsq_ram #(
		.WIDTH(ITEM_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (in_acc && ram_we),
		.waddr(ram_waddr),
		.wdata(item),
		.re   (in_acc && rd_op),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// counters, config and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= INIT_CAP_RST;
			blk_q   <= BLOCK_RST;
			count_q <= '0;
			cap_q   <= VW'(INIT_CAP_RST);
			state_q <= STATE_IDLE;
		end else begin
			if (cfg_we) begin
				// any register write re-creates an empty stack
				unique case (reg_idx_t'(cfg_index))
					REG_INIT_CAP: begin
						init_q <= cfg_data;
						cap_q  <= VW'(cfg_data);
					end
					REG_BLOCK: begin
						blk_q <= cfg_data;
						cap_q <= init_v;
					end
					default: begin
						cap_q <= init_v;
					end
				endcase
				count_q <= '0;
			end else if (in_acc) begin
				count_q <= nxt_count;
				cap_q   <= nxt_cap;
			end
			unique case (state_q)
				STATE_IDLE: begin
					if (in_acc && rd_op) begin
						state_q <= STATE_READ;
					end
				end
				STATE_READ: begin
					state_q <= STATE_IDLE;
				end
				default: begin
					state_q <= STATE_IDLE;
				end
			endcase
		end
	end

	// result register: direct for items without a read, from ram data for reads
	logic load_direct, load_read;
	assign load_direct = in_acc && !rd_op;
	assign load_read   = (state_q == STATE_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || load_read) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_status_q <= nxt_status;
			out_item_q   <= '0;
			out_count_q  <= nxt_count[OUT_CNT_W-1:0];
			out_cap_q    <= nxt_cap[OUT_CNT_W-1:0];
		end else if (load_read) begin
			// counters already hold the post-operation values
			out_status_q <= ST_OK;
			out_item_q   <= ram_rdata;
			out_count_q  <= count_q[OUT_CNT_W-1:0];
			out_cap_q    <= cap_q[OUT_CNT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_cap_q, out_count_q,
		out_item_q, out_status_q};

`ifndef NO_ASSERTIONS
	a_read_goes_wait: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && rd_op |=> state_q == STATE_READ)
		else $error("read item did not enter wait state");
	a_wait_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == STATE_READ |=> out_valid_q)
		else $error("read result not loaded");
	a_no_intake_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == STATE_READ |-> !s_axis_tready)
		else $error("intake during read wait");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_V)
		else $error("item count beyond depth");
`endif

endmodule
`default_nettype wire

[tb/bounded_stack_with_capacity_quota_unit_tb.sv]
module bounded_stack_with_capacity_quota_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsq_pkg::*;

	localparam int STORE_DEPTH = DEPTH_DEF;
	// slack needed before a remove gives one block back
	localparam int SHRINK_BLOCKS = 2;
	// cycles with no item moving on either side before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	localparam int REPORT_MAX = 10;

	// one operation as the sender sees it
	typedef struct {
		func_t        op;
		logic [9:0]   idx;
		logic [31:0]  value;
		bit           drain_first;   // hold this item until every result is back
	} stack_req_t;

	// one result as the block should answer it
	typedef struct {
		status_t      status;
		logic [31:0]  item;
		logic [10:0]  count;
		logic [10:0]  cap;
	} stack_resp_t;

	typedef enum {GROWING, DRAINING, CHURNING} load_trend_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	// func[1:0], index[11:2], item_value[43:12], zero fill above
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// status[2:0], item_out[34:3], item_count[45:35], capacity_now[56:46], zero fill above
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;

	bounded_stack_with_capacity_quota_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// shadow of the stack: contents, fill level, capacity and both registers
	logic [31:0]  shadow_store [0:STORE_DEPTH-1];
	int           mdl_count = 0;
	int           mdl_cap = 16;
	int           mdl_init = 16;
	int           mdl_block = 16;

	stack_req_t   pending_items[$];
	stack_resp_t  awaited_responses[$];
	stack_req_t   in_flight;
	int           n_sent = 0;
	int           n_recv = 0;
	int           fault_count = 0;
	int           send_gap = 0;
	int           send_calm = 0;
	int           recv_gap = 0;
	int           recv_calm = 0;
	bit           send_took;
	int           idle_cycles = 0;

	// stimulus shaping state
	int           fill_guess = 0;
	load_trend_t  trend = CHURNING;
	int           trend_left = 0;

	// apply one operation to the shadow stack and return what the block must answer
	function automatic stack_resp_t predict_stack_op(stack_req_t r);
		stack_resp_t o;
		int limit;
		o.status = ST_OK;
		o.item = '0;
		if (mdl_init == 0 && mdl_block == 0) begin
			// unusable configuration rejects everything
			o.status = ST_INVALID;
		end else begin
			case (r.op)
				FN_APPEND: begin
					if (r.value == '0) begin
						o.status = ST_INVALID;
					end else begin
						limit = (mdl_cap < STORE_DEPTH) ? mdl_cap : STORE_DEPTH;
						if (mdl_count >= limit) begin
							// full: grow by a block if allowed and it still fits
							if (mdl_block == 0)
								o.status = ST_OVERFLOW;
							else if (mdl_cap + mdl_block > STORE_DEPTH)
								o.status = ST_GROW;
							else
								mdl_cap += mdl_block;
						end
						if (o.status == ST_OK && mdl_count < STORE_DEPTH) begin
							shadow_store[mdl_count] = r.value;
							mdl_count++;
						end else if (o.status == ST_OK) begin
							o.status = ST_GROW;
						end
					end
				end
				FN_REMOVE: begin
					if (mdl_count == 0) begin
						o.status = ST_OVERFLOW;
					end else begin
						// give a block back before the pop when slack allows, not below the floor
						if (mdl_cap >= mdl_block && mdl_cap >= mdl_count &&
								mdl_cap - mdl_count >= mdl_block * SHRINK_BLOCKS &&
								mdl_cap - mdl_block >= mdl_init)
							mdl_cap -= mdl_block;
						o.item = shadow_store[mdl_count - 1];
						mdl_count--;
					end
				end
				FN_GET: begin
					if (r.idx >= mdl_count)
						o.status = ST_BOUNDS;
					else
						o.item = shadow_store[r.idx];
				end
				default: begin
					if (r.value == '0)
						o.status = ST_INVALID;
					else if (r.idx >= mdl_count)
						o.status = ST_BOUNDS;
					else
						shadow_store[r.idx] = r.value;
				end
			endcase
		end
		o.count = 11'(mdl_count);
		o.cap = 11'(mdl_cap);
		return o;
	endfunction

	// per item random wait, with calm stretches that never wait
	function automatic int pick_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	// sender: presents queued items, predicts each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			n_sent <= 0;
			send_gap = 0;
		end else begin
			send_took = s_axis_tvalid && s_axis_tready;
			if (send_took) begin
				awaited_responses.push_back(predict_stack_op(in_flight));
				n_sent <= n_sent + 1;
				send_gap = pick_idle(send_calm);
			end
			if (s_axis_tvalid && !send_took) begin
				// item still on the bus, keep it there
			end else if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0 &&
					(!pending_items[0].drain_first || n_recv == n_sent + int'(send_took))) begin
				in_flight = pending_items.pop_front();
				s_axis_tdata <= IN_TDATA_W'({in_flight.value, in_flight.idx, in_flight.op});
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure, every result checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			n_recv <= 0;
			recv_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_recv <= n_recv + 1;
				recv_gap = pick_idle(recv_calm);
				if (awaited_responses.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("[%0t] result with nothing pending: tdata=%h", $realtime,
							m_axis_tdata);
				end else begin
					stack_resp_t want;
					want = awaited_responses.pop_front();
					if (m_axis_tdata[2:0] !== want.status || m_axis_tdata[34:3] !== want.item ||
							m_axis_tdata[45:35] !== want.count ||
							m_axis_tdata[56:46] !== want.cap) begin
						fault_count++;
						if (fault_count <= REPORT_MAX)
							$display("[%0t] exp/act status %0d/%0d item %h/%h",
								$realtime, want.status, m_axis_tdata[2:0], want.item,
								m_axis_tdata[34:3], " count %0d/%0d cap %0d/%0d",
								want.count, m_axis_tdata[45:35],
								want.cap, m_axis_tdata[56:46]);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// hang detector: no item moving on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= HANG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", HANG_LIMIT);
				$display("bounded_stack_with_capacity_quota_unit verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic queue_op(input func_t op, input int idx, input logic [31:0] value,
			input bit drain_first);
		stack_req_t r;
		r.op = op;
		r.idx = 10'(idx);
		r.value = value;
		r.drain_first = drain_first;
		pending_items.push_back(r);
	endtask

	// block until everything queued is sent and answered, checked between edges
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || n_recv != n_sent);
	endtask

	// write both registers while the block is idle; the write also empties the stack
	task automatic reprogram(input int cap0, input int step);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_INIT_CAP;
		cfg_data <= CFG_W'(cap0);
		@(posedge clk);
		cfg_index <= REG_BLOCK;
		cfg_data <= CFG_W'(step);
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_init = cap0;
		mdl_block = step;
		mdl_count = 0;
		mdl_cap = cap0;
		fill_guess = 0;
	endtask

	// random operations in trends, so the stack fills, drains and churns in turn
	task automatic queue_mixed(input int n);
		int roll;
		int a_lim;
		int r_lim;
		int g_lim;
		int idx;
		logic [31:0] value;
		func_t op;
		for (int k = 0; k < n; k++) begin
			if (trend_left == 0) begin
				trend = load_trend_t'($urandom_range(0, 2));
				trend_left = $urandom_range(5, 40);
			end
			trend_left--;
			case (trend)
				GROWING:  begin a_lim = 65; r_lim = 75; g_lim = 88; end
				DRAINING: begin a_lim = 20; r_lim = 70; g_lim = 85; end
				default:  begin a_lim = 35; r_lim = 60; g_lim = 80; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < a_lim)
				op = FN_APPEND;
			else if (roll < r_lim)
				op = FN_REMOVE;
			else if (roll < g_lim)
				op = FN_GET;
			else
				op = FN_SET;
			// mostly nonzero handles, sometimes null or all ones
			roll = $urandom_range(0, 15);
			if (roll == 0)
				value = '0;
			else if (roll == 1)
				value = '1;
			else
				value = $urandom;
			// indices mostly near the live range, including one past the top
			if ($urandom_range(0, 3) == 0)
				idx = $urandom_range(0, 1023);
			else
				idx = $urandom_range(0, (fill_guess < 1023) ? fill_guess : 1023);
			queue_op(op, idx, value, $urandom_range(0, 149) == 0);
			if (op == FN_APPEND && value != '0 && fill_guess < STORE_DEPTH)
				fill_guess++;
			else if (op == FN_REMOVE && fill_guess > 0)
				fill_guess--;
		end
	endtask

	initial begin
		logic [31:0] v;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, on the reset configuration of 16 and 16
		queue_op(FN_REMOVE, 0, 32'h0, 1'b0);                // remove from empty stack
		queue_op(FN_GET, 0, 32'h0, 1'b0);                   // get from empty stack
		queue_op(FN_APPEND, 0, 32'h0, 1'b0);                // null append
		queue_op(FN_APPEND, 0, 32'hFFFF_FFFF, 1'b0);
		queue_op(FN_APPEND, 1023, 32'h0000_0001, 1'b0);
		queue_op(FN_SET, 1023, 32'hFFFF_FFFF, 1'b0);        // index far out of range
		queue_op(FN_SET, 0, 32'h0, 1'b0);                   // null set
		queue_op(FN_SET, 1, 32'hA5A5_5A5A, 1'b0);
		queue_op(FN_GET, 1, 32'h0, 1'b0);
		queue_op(FN_GET, 2, 32'h0, 1'b0);                   // one past the top
		// fill past the first capacity so it grows by a block
		for (int k = 0; k < 15; k++)
			queue_op(FN_APPEND, 0, 32'h1000_0000 + k, 1'b0);
		queue_op(FN_REMOVE, 0, 32'h0, 1'b1);                // sender drains first
		queue_op(FN_GET, 15, 32'h0, 1'b0);
		fill_guess = 16;
		queue_mixed(60);

		// both registers zero: everything rejected
		reprogram(0, 0);
		queue_mixed(15);
		// no growth allowed: overflow on a full store
		reprogram(4, 0);
		queue_mixed(35);
		// capacity below the block size, shrink cannot fire before a growth
		reprogram(3, 8);
		queue_mixed(40);
		// tiny blocks, lots of grow and shrink around a floor of one
		reprogram(1, 2);
		queue_mixed(70);
		// a single growth step would pass the depth
		reprogram(8, 1024);
		queue_mixed(25);
		// empty start that grows straight to the full depth
		reprogram(0, 1024);
		queue_mixed(30);

		// fill the whole physical store, then push against it
		reprogram(1020, 4);
		for (int k = 0; k < 1100; k++) begin
			v = $urandom;
			if (v == '0)
				v = 32'h1;
			if (k % 16 == 15)
				queue_op(FN_GET, $urandom_range(0, k), 32'h0, 1'b0);
			else
				queue_op(FN_APPEND, 0, v, 1'b0);
		end
		fill_guess = STORE_DEPTH;
		queue_mixed(20);

		// both registers at the store depth
		reprogram(1024, 1024);
		queue_mixed(20);
		// back to the reset setting through the write port
		reprogram(16, 16);
		queue_mixed(60);

		wait_drained();
		repeat (6) @(posedge clk);
		if (awaited_responses.size() != 0) begin
			fault_count += awaited_responses.size();
			$display("%0d results never arrived", awaited_responses.size());
		end
		if (fault_count == 0) begin
			$display("bounded_stack_with_capacity_quota_unit verification clean");
		end else begin
			$display("bounded_stack_with_capacity_quota_unit verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/bsq_pkg.sv
rtl/bsq_ram.sv
rtl/bounded_stack_with_capacity_quota_unit.sv
tb/bounded_stack_with_capacity_quota_unit_tb.sv
